// ----- src/mssc_pkg.sv -----
package mssc_pkg;

  localparam int SAMPLE_W = 24;
  localparam int SIDE_W = 25;
  localparam int THR_W = 15;
  localparam int N_W = 11;
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W = 56;
  localparam int IN_USER_W = 4;
  localparam int OUT_DATA_W = 72;

  localparam int DEF_FRAME_SIZE = 1024;
  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_NUM_CHANNELS = 8;
  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_MAX_RST = 15'd32767;
  localparam logic [THR_W-1:0] THR_MIN_RST = 15'd0;
  localparam logic [THR_W-1:0] THR_STEP_RST = 15'd328;

  localparam logic [CFG_IDX_W-1:0] REG_THR_MAX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_STEP = 2'd2;

  localparam int MUL_W = 72;
  localparam int PROD_W = 144;

  typedef struct packed {
    logic signed [23:0] mid;
    logic signed [24:0] side;
    logic done;
    logic [THR_W-1:0] thr;
    logic [N_W-1:0] n;
    logic signed [34:0] sl;
    logic signed [34:0] sr;
    logic signed [56:0] sll;
    logic signed [56:0] srr;
    logic signed [57:0] slr;
    logic signed [34:0] sm;
    logic signed [35:0] ss;
    logic signed [56:0] smm;
    logic signed [58:0] sss;
    logic signed [58:0] sms;
  } entry_t;

endpackage

// ----- src/mssc_fifo.sv -----
module mssc_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [W-1:0] din,
  input  logic pop,
  output logic [W-1:0] dout,
  output logic empty,
  output logic [$clog2(DEPTH+1)-1:0] level
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(DEPTH + 1);

  logic [W-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic do_pop;

  assign empty = (lvl_r == '0);
  assign level = lvl_r;
  assign dout = mem_r[rp_r];
  assign do_pop = pop && !empty;

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    lvl_nxt = lvl_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (push && !do_pop) begin
      lvl_nxt = lvl_r + 1'b1;
    end else if (!push && do_pop) begin
      lvl_nxt = lvl_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      lvl_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule

// ----- src/mssc_front.sv -----
module mssc_front #(
  parameter int FRAME_SIZE = 1024,
  parameter int SAMPLE_BITS = 24,
  parameter int NUM_CHANNELS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [mssc_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic [mssc_pkg::IN_USER_W-1:0] in_tuser,
  input  logic in_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mssc_pkg::THR_W-1:0] cfg_data,
  input  logic [mssc_pkg::Q_CNT_W-1:0] q_level,
  output logic q_push,
  output mssc_pkg::entry_t q_entry
);
  import mssc_pkg::*;

  localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(FRAME_SIZE + 1);

  logic [THR_W-1:0] tmax_r, tmin_r, tstep_r;
  logic [THR_W-1:0] tbl_r [NUM_CHANNELS];
  logic [THR_W-1:0] tbl_nxt [NUM_CHANNELS];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;

  logic stg_v_r, stg_v_nxt, stg_push_r, stg_done_r;
  logic [THR_W-1:0] stg_thr_r, stg_thr_nxt;
  logic [N_W-1:0] stg_n_r;
  logic signed [23:0] stg_l_r, stg_rt_r, stg_m_r;
  logic signed [24:0] stg_s_r;

  logic signed [34:0] sl_r, sr_r, sm_r, sl_nx, sr_nx, sm_nx;
  logic signed [35:0] ss_r, ss_nx;
  logic signed [56:0] sll_r, srr_r, smm_r, sll_nx, srr_nx, smm_nx;
  logic signed [57:0] slr_r, slr_nx;
  logic signed [58:0] sss_r, sms_r, sss_nx, sms_nx;

  logic acc;
  logic act, fend, found;
  logic [2:0] chan;
  logic [CH_W-1:0] ch;
  logic [THR_W-1:0] thr_cur;
  logic signed [16:0] t_dec, t_inc, t_new;
  logic signed [23:0] l_raw, r_raw, l_s, r_s;
  logic signed [24:0] sum_lr, side;
  logic done;

  assign act = in_tuser[0];
  assign chan = in_tuser[3:1];
  assign found = in_tdata[48];
  assign fend = in_tlast;
  assign cfg_ready = 1'b1;

  assign in_tready = ({1'b0, q_level} + (Q_CNT_W + 1)'(stg_v_r)) < (Q_CNT_W + 1)'(Q_DEPTH);
  assign acc = in_tvalid && in_tready;

  assign ch = (4'(chan) >= 4'(NUM_CHANNELS)) ? CH_W'(NUM_CHANNELS - 1) : CH_W'(chan);
  assign thr_cur = tbl_r[ch];

  assign l_raw = in_tdata[23:0] << SHIFT;
  assign r_raw = in_tdata[47:24] << SHIFT;
  assign l_s = l_raw >>> SHIFT;
  assign r_s = r_raw >>> SHIFT;
  assign sum_lr = 25'(l_s) + 25'(r_s);
  assign side = 25'(l_s) - 25'(r_s);

  assign cnt_inc = cnt_r + 1'b1;
  assign done = fend || (cnt_inc >= CNT_W'(FRAME_SIZE));

  always_comb begin
    t_dec = $signed({2'b00, thr_cur}) - $signed({2'b00, tstep_r});
    t_inc = $signed({2'b00, thr_cur}) + $signed({2'b00, tstep_r});
    if (found) begin
      t_new = (t_dec < $signed({2'b00, tmin_r})) ? $signed({2'b00, tmin_r}) : t_dec;
    end else begin
      t_new = (t_inc > $signed({2'b00, tmax_r})) ? $signed({2'b00, tmax_r}) : t_inc;
    end
  end

  always_comb begin
    tbl_nxt = tbl_r;
    cnt_nxt = cnt_r;
    stg_v_nxt = acc;
    stg_thr_nxt = thr_cur;
    if (acc && act) begin
      tbl_nxt[ch] = t_new[THR_W-1:0];
      stg_thr_nxt = t_new[THR_W-1:0];
    end
    if (acc && !act) begin
      cnt_nxt = done ? '0 : cnt_inc;
    end
  end

  always_comb begin
    sl_nx = sl_r + 35'(stg_l_r);
    sr_nx = sr_r + 35'(stg_rt_r);
    sll_nx = sll_r + 57'(stg_l_r * stg_l_r);
    srr_nx = srr_r + 57'(stg_rt_r * stg_rt_r);
    slr_nx = slr_r + 58'(stg_l_r * stg_rt_r);
    sm_nx = sm_r + 35'(stg_m_r);
    ss_nx = ss_r + 36'(stg_s_r);
    smm_nx = smm_r + 57'(stg_m_r * stg_m_r);
    sss_nx = sss_r + 59'(stg_s_r * stg_s_r);
    sms_nx = sms_r + 59'(stg_m_r * stg_s_r);
  end

  always_comb begin
    q_push = stg_v_r;
    q_entry.mid = stg_push_r ? stg_m_r : '0;
    q_entry.side = stg_push_r ? stg_s_r : '0;
    q_entry.done = stg_push_r && stg_done_r;
    q_entry.thr = stg_thr_r;
    q_entry.n = stg_n_r;
    q_entry.sl = sl_nx;
    q_entry.sr = sr_nx;
    q_entry.sll = sll_nx;
    q_entry.srr = srr_nx;
    q_entry.slr = slr_nx;
    q_entry.sm = sm_nx;
    q_entry.ss = ss_nx;
    q_entry.smm = smm_nx;
    q_entry.sss = sss_nx;
    q_entry.sms = sms_nx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmax_r <= THR_MAX_RST;
      tmin_r <= THR_MIN_RST;
      tstep_r <= THR_STEP_RST;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tbl_r[i] <= THR_MAX_RST;
      end
      cnt_r <= '0;
      stg_v_r <= 1'b0;
      sl_r <= '0;
      sr_r <= '0;
      sll_r <= '0;
      srr_r <= '0;
      slr_r <= '0;
      sm_r <= '0;
      ss_r <= '0;
      smm_r <= '0;
      sss_r <= '0;
      sms_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_THR_MAX: tmax_r <= cfg_data;
          REG_THR_MIN: tmin_r <= cfg_data;
          REG_THR_STEP: tstep_r <= cfg_data;
          default: ;
        endcase
      end
      tbl_r <= tbl_nxt;
      cnt_r <= cnt_nxt;
      stg_v_r <= stg_v_nxt;
      if (stg_v_r && stg_push_r) begin
        if (stg_done_r) begin
          sl_r <= '0;
          sr_r <= '0;
          sll_r <= '0;
          srr_r <= '0;
          slr_r <= '0;
          sm_r <= '0;
          ss_r <= '0;
          smm_r <= '0;
          sss_r <= '0;
          sms_r <= '0;
        end else begin
          sl_r <= sl_nx;
          sr_r <= sr_nx;
          sll_r <= sll_nx;
          srr_r <= srr_nx;
          slr_r <= slr_nx;
          sm_r <= sm_nx;
          ss_r <= ss_nx;
          smm_r <= smm_nx;
          sss_r <= sss_nx;
          sms_r <= sms_nx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stg_push_r <= !act;
      stg_done_r <= done;
      stg_thr_r <= stg_thr_nxt;
      stg_n_r <= N_W'(cnt_inc);
      stg_l_r <= l_s;
      stg_rt_r <= r_s;
      stg_m_r <= sum_lr[24:1];
      stg_s_r <= side;
    end
  end
endmodule

// ----- src/mssc_mul.sv -----
module mssc_mul (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [mssc_pkg::MUL_W-1:0] a,
  input  logic signed [mssc_pkg::MUL_W-1:0] b,
  output logic done,
  output logic signed [mssc_pkg::PROD_W-1:0] p
);
  import mssc_pkg::*;

  localparam int STEPS = MUL_W / 8;

  logic [MUL_W-1:0] am_r, a_mag, b_mag;
  logic [PROD_W-1:0] bs_r, acc_r, acc_sum;
  logic [PROD_W+7:0] part;
  logic neg_r, run_r, done_r;
  logic [3:0] cnt_r;
  logic signed [PROD_W-1:0] p_r;

  assign a_mag = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
  assign b_mag = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);
  assign part = bs_r * am_r[7:0];
  assign acc_sum = acc_r + part[PROD_W-1:0];
  assign done = done_r;
  assign p = p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 4'(STEPS - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      am_r <= a_mag;
      bs_r <= PROD_W'(b_mag);
      acc_r <= '0;
      neg_r <= a[MUL_W-1] ^ b[MUL_W-1];
    end else if (run_r) begin
      am_r <= am_r >> 8;
      bs_r <= bs_r << 8;
      acc_r <= acc_sum;
      if (cnt_r == 4'(STEPS - 1)) begin
        p_r <= neg_r ? -$signed(acc_sum) : $signed(acc_sum);
      end
    end
  end
endmodule

// ----- src/mssc_corr.sv -----
module mssc_corr (
  input  logic clk,
  input  logic rst_n,
  input  mssc_pkg::entry_t q_entry,
  input  logic q_empty,
  output logic q_pop,
  output logic out_tvalid,
  input  logic out_tready,
  output logic [mssc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic out_tlast
);
  import mssc_pkg::*;

  localparam int RW = 176;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MSTART = 3'd1;
  localparam logic [2:0] S_MWAIT = 3'd2;
  localparam logic [2:0] S_ROOT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  localparam logic [2:0] OP_NXY = 3'd0;
  localparam logic [2:0] OP_XY = 3'd1;
  localparam logic [2:0] OP_NXX = 3'd2;
  localparam logic [2:0] OP_XX = 3'd3;
  localparam logic [2:0] OP_NYY = 3'd4;
  localparam logic [2:0] OP_YY = 3'd5;
  localparam logic [2:0] OP_VV = 3'd6;
  localparam logic [2:0] OP_CC = 3'd7;

  logic [2:0] st_r, st_nxt, op_r;
  logic set_r;
  logic signed [MUL_W-1:0] t_r, c_r, vx_r, vy_r;
  logic [PROD_W-1:0] pp_r;
  logic [RW-1:0] rem_r, tk_r, pj_r, dd;
  logic [15:0] k_r, k_new;
  logic [3:0] j_r;
  logic signed [16:0] rlr_r, rms_r, r_val;
  logic out_v_r;
  logic [OUT_DATA_W-1:0] out_d_r;
  logic out_l_r;

  logic signed [MUL_W-1:0] n72, sx, sy, sxx, syy, sxy, ma, mb;
  logic mul_start, mul_done, fit, load, use_ms;
  logic signed [PROD_W-1:0] prod;

  mssc_mul u_mul (
    .clk(clk),
    .rst_n(rst_n),
    .start(mul_start),
    .a(ma),
    .b(mb),
    .done(mul_done),
    .p(prod)
  );

  // Sums of squares are never negative, so sll, srr and smm are taken as unsigned.
  always_comb begin
    n72 = $signed({{(MUL_W - N_W){1'b0}}, q_entry.n});
    if (!set_r) begin
      sx = q_entry.sl;
      sy = q_entry.sr;
      sxx = MUL_W'({1'b0, q_entry.sll});
      syy = MUL_W'({1'b0, q_entry.srr});
      sxy = q_entry.slr;
    end else begin
      sx = q_entry.sm;
      sy = q_entry.ss;
      sxx = MUL_W'({1'b0, q_entry.smm});
      syy = q_entry.sss;
      sxy = q_entry.sms;
    end
    unique case (op_r)
      OP_NXY: begin ma = n72; mb = sxy; end
      OP_XY: begin ma = sx; mb = sy; end
      OP_NXX: begin ma = n72; mb = sxx; end
      OP_XX: begin ma = sx; mb = sx; end
      OP_NYY: begin ma = n72; mb = syy; end
      OP_YY: begin ma = sy; mb = sy; end
      OP_VV: begin ma = vx_r; mb = vy_r; end
      OP_CC: begin ma = c_r; mb = c_r; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign mul_start = (st_r == S_MSTART);
  assign dd = ((tk_r << 1) + pj_r) << j_r;
  assign fit = (dd <= rem_r);
  assign k_new = fit ? (k_r | (16'd1 << j_r)) : k_r;

  always_comb begin
    if ((vx_r <= 0) || (vy_r <= 0)) begin
      r_val = '0;
    end else if (c_r[MUL_W-1]) begin
      r_val = -$signed({1'b0, k_new});
    end else begin
      r_val = $signed({1'b0, k_new});
    end
  end

  assign load = (st_r == S_EMIT) && (!out_v_r || out_tready);
  assign q_pop = load;
  assign use_ms = q_entry.done && (rlr_r > $signed({2'b00, q_entry.thr})) && (rlr_r > rms_r);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          st_nxt = q_entry.done ? S_MSTART : S_EMIT;
        end
      end
      S_MSTART: st_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          st_nxt = (op_r == OP_CC) ? S_ROOT : S_MSTART;
        end
      end
      S_ROOT: begin
        if (j_r == '0) begin
          st_nxt = set_r ? S_EMIT : S_MSTART;
        end
      end
      S_EMIT: begin
        if (load) begin
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      op_r <= OP_NXY;
      set_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_IDLE) begin
        op_r <= OP_NXY;
        set_r <= 1'b0;
      end
      if (st_r == S_MWAIT && mul_done && op_r != OP_CC) begin
        op_r <= op_r + 1'b1;
      end
      if (st_r == S_ROOT && j_r == '0) begin
        op_r <= OP_NXY;
        set_r <= 1'b1;
      end
      if (load) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_MWAIT && mul_done) begin
      case (op_r) inside
        OP_NXY, OP_NXX, OP_NYY: t_r <= MUL_W'(prod);
        OP_XY: c_r <= t_r - MUL_W'(prod);
        OP_XX: vx_r <= t_r - MUL_W'(prod);
        OP_YY: vy_r <= t_r - MUL_W'(prod);
        OP_VV: pp_r <= prod;
        default: begin
          rem_r <= RW'(prod) << 30;
          pj_r <= RW'(pp_r) << 15;
          tk_r <= '0;
          k_r <= '0;
          j_r <= 4'd15;
        end
      endcase
    end
    if (st_r == S_ROOT) begin
      if (fit) begin
        rem_r <= rem_r - dd;
        tk_r <= tk_r + pj_r;
      end
      k_r <= k_new;
      pj_r <= pj_r >> 1;
      j_r <= j_r - 1'b1;
      if (j_r == '0) begin
        if (set_r) begin
          rms_r <= r_val;
        end else begin
          rlr_r <= r_val;
        end
      end
    end
    if (load) begin
      out_d_r <= {7'd0, q_entry.thr, use_ms, q_entry.side, q_entry.mid};
      out_l_r <= q_entry.done;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;
  assign out_tlast = out_l_r;
endmodule

// ----- src/mid_side_correlation_select_core.sv -----
// Mid/side stereo correlation decision core.
// The input stream carries one word per sample pair or threshold update.
// in_tuser selects the action and the channel, and in_tlast marks the last
// sample of a frame. Each accepted word yields exactly one output word
// holding mid, side, the decision flag and a threshold; out_tlast marks the
// result of a frame's last sample. The configuration channel writes the
// threshold limits and step and is always ready; write it only when idle.
// An ordinary word passes the staging register, the queue and the emit state
// into the output register. A frame's last sample needs sixteen products on
// one shared eight-bit per cycle multiplier and two sixteen-step square root
// searches. The front accepts one word per cycle while the four-entry queue
// has room, and the back end retires one queue entry at a time.
// When the receiver stalls, the output register holds its word and the
// queue fills, after which in_tready falls. Reset clears the sums, sets
// every threshold to the maximum and restores the register defaults.
module mid_side_correlation_select_core #(
  parameter int FRAME_SIZE = mssc_pkg::DEF_FRAME_SIZE,
  parameter int SAMPLE_BITS = mssc_pkg::DEF_SAMPLE_BITS,
  parameter int NUM_CHANNELS = mssc_pkg::DEF_NUM_CHANNELS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // left_sample, right_sample, corr_found, zero pad
  input  logic [mssc_pkg::IN_DATA_W-1:0] in_tdata,
  // action, channel
  input  logic [mssc_pkg::IN_USER_W-1:0] in_tuser,
  input  logic in_tlast,
  output logic out_tvalid,
  input  logic out_tready,
  // mid_sample, side_sample, use_mid_side, new_threshold, zero pad
  output logic [mssc_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic out_tlast,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [mssc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mssc_pkg::THR_W-1:0] cfg_data
);
  import mssc_pkg::*;

  entry_t q_in, q_out;
  logic q_push, q_pop, q_empty;
  logic [Q_CNT_W-1:0] q_level;

  mssc_front #(
    .FRAME_SIZE(FRAME_SIZE),
    .SAMPLE_BITS(SAMPLE_BITS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_level(q_level),
    .q_push(q_push),
    .q_entry(q_in)
  );

  mssc_fifo #(
    .W($bits(entry_t)),
    .DEPTH(Q_DEPTH)
  ) u_fifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(q_push),
    .din(q_in),
    .pop(q_pop),
    .dout(q_out),
    .empty(q_empty),
    .level(q_level)
  );

  mssc_corr u_corr (
    .clk(clk),
    .rst_n(rst_n),
    .q_entry(q_out),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );
endmodule
